/* design/zero_run_segmenter_top_assert.svh */
// ----------------------------------------------------------------------------
// zero run segmenter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_SEGMENTER_TOP_ASSERT_SVH
`define ZERO_RUN_SEGMENTER_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define ZRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define ZRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/zrs_pkg.sv */
// ----------------------------------------------------------------------------
// zrs_pkg
// Types and constants shared by the zero run segmenter and its channels.
// ----------------------------------------------------------------------------
package zrs_pkg;

  // width of the reported record lengths
  localparam int OUT_WIDTH = 32;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

  // threshold register
  localparam int THR_WIDTH = 8;
  localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET = 8'd8;

  // result queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef logic [OUT_WIDTH-1:0] len_t;

  typedef struct packed {
    len_t data_length;
    len_t zero_length;
    logic final_record;
  } record_t;

  // clip a counter value to the reported width
  function automatic len_t clip_count(input logic [63:0] value);
    len_t clipped;
    if (value > 64'(OUT_MAX)) begin
      clipped = OUT_MAX;
    end else begin
      clipped = value[OUT_WIDTH-1:0];
    end
    return clipped;
  endfunction

endpackage

/* design/zrs_channels.sv */
// ----------------------------------------------------------------------------
// zrs channels
// Valid/ready channels for stream bytes in and records out.
// ----------------------------------------------------------------------------

// byte channel
interface zrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// record channel
interface zrs_out_if;
  logic                         valid;
  logic                         ready;
  logic [zrs_pkg::OUT_WIDTH-1:0] data_length;
  logic [zrs_pkg::OUT_WIDTH-1:0] zero_length;
  logic                         final_record;

  modport source (output valid, output data_length, output zero_length,
                  output final_record, input ready);
  modport sink   (input valid, input data_length, input zero_length,
                  input final_record, output ready);
endinterface

/* design/zero_run_segmenter_top.sv */
// ----------------------------------------------------------------------------
// zero_run_segmenter_top
// Splits a byte stream into (kept bytes, dropped zeroes) records.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while byte_in.ready is high and updates the
// two run counters with each transfer; a record enters the queue with the byte
// transfer that closes it. Records wait in a four-entry queue, and byte_in.ready is
// high while at least two entries are free, so bytes keep flowing at one per
// cycle while the record sink keeps up. A byte that closes a long zero run and
// also ends the stream yields two records.
// zero_threshold (reset 8) may only be written while no records are pending.
// ----------------------------------------------------------------------------
`include "zero_run_segmenter_top_assert.svh"

module zero_run_segmenter_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [zrs_pkg::THR_WIDTH-1:0]     cfg_data,
  zrs_in_if.sink                            byte_in,
  zrs_out_if.source                         rec_out
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [zrs_pkg::QUEUE_CW-1:0] FILL_MAX = zrs_pkg::QUEUE_CW'(zrs_pkg::QUEUE_DEPTH);
  localparam logic [zrs_pkg::QUEUE_CW-1:0] FILL_OPEN =
    zrs_pkg::QUEUE_CW'(zrs_pkg::QUEUE_DEPTH - 2);

  logic [zrs_pkg::THR_WIDTH-1:0] zero_threshold;
  logic [COUNT_WIDTH-1:0]        kept_count;
  logic [COUNT_WIDTH-1:0]        zero_run_count;
  logic [COUNT_WIDTH-1:0]        kept_next;
  logic [COUNT_WIDTH-1:0]        zero_run_next;
  logic [COUNT_WIDTH-1:0]        kept_upd;
  logic [COUNT_WIDTH-1:0]        run_upd;
  logic [COUNT_WIDTH-1:0]        kept_base;
  logic [COUNT_WIDTH-1:0]        fold_add;
  logic [COUNT_WIDTH:0]          kept_sum;

  logic in_xfer;
  logic out_xfer;
  logic byte_nz;
  logic run_open;
  logic long_run;
  logic close_rec;
  logic end_rec;

  zrs_pkg::record_t rec_close;
  zrs_pkg::record_t rec_last;
  zrs_pkg::record_t queue [zrs_pkg::QUEUE_DEPTH];

  logic [zrs_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [zrs_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [zrs_pkg::QUEUE_CW-1:0] fill;
  logic [1:0]                   push_n;

  // handshakes
  assign in_xfer  = byte_in.valid && byte_in.ready;
  assign out_xfer = rec_out.valid && rec_out.ready;
  assign byte_in.ready = (fill <= FILL_OPEN);

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= zrs_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      zero_threshold <= cfg_data;
    end
  end

  // run classification
  assign byte_nz   = (byte_in.data_byte != '0);
  assign run_open  = (zero_run_count != '0);
  assign long_run  = run_open && (zero_run_count > COUNT_WIDTH'(zero_threshold));
  assign close_rec = byte_nz && long_run;
  assign end_rec   = byte_in.end_of_stream;

  // kept count: fold a short run and add this byte, saturating
  assign kept_base = long_run ? '0 : kept_count;
  assign fold_add  = long_run ? '0 : zero_run_count;
  assign kept_sum  = {1'b0, kept_base} + {1'b0, fold_add} + (COUNT_WIDTH + 1)'(1);

  always_comb begin
    if (byte_nz) begin
      kept_upd = kept_sum[COUNT_WIDTH] ? COUNT_MAX : kept_sum[COUNT_WIDTH-1:0];
      run_upd  = '0;
    end else begin
      kept_upd = kept_count;
      run_upd  = (zero_run_count == COUNT_MAX) ? COUNT_MAX
                                                : zero_run_count + COUNT_WIDTH'(1);
    end
  end

  // state after this byte
  always_comb begin
    if (end_rec) begin
      kept_next     = '0;
      zero_run_next = '0;
    end else begin
      kept_next     = kept_upd;
      zero_run_next = run_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count     <= '0;
      zero_run_count <= '0;
    end else if (in_xfer) begin
      kept_count     <= kept_next;
      zero_run_count <= zero_run_next;
    end
  end

  // records produced by this byte
  always_comb begin
    rec_close.data_length  = zrs_pkg::clip_count(64'(kept_count));
    rec_close.zero_length  = zrs_pkg::clip_count(64'(zero_run_count));
    rec_close.final_record = 1'b0;
    rec_last.data_length   = zrs_pkg::clip_count(64'(kept_upd));
    rec_last.zero_length   = zrs_pkg::clip_count(64'(run_upd));
    rec_last.final_record  = 1'b1;
  end

  assign push_n = in_xfer ? ({1'b0, close_rec} + {1'b0, end_rec}) : 2'd0;

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (close_rec) begin
        queue[wr_ptr] <= rec_close;
      end
      if (end_rec) begin
        queue[close_rec ? wr_ptr + zrs_pkg::QUEUE_AW'(1) : wr_ptr] <= rec_last;
      end
    end
  end

  // result queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + zrs_pkg::QUEUE_AW'(push_n);
      rd_ptr <= rd_ptr + zrs_pkg::QUEUE_AW'(out_xfer);
      fill   <= fill + zrs_pkg::QUEUE_CW'(push_n) - zrs_pkg::QUEUE_CW'(out_xfer);
    end
  end

  // output side
  assign rec_out.valid        = (fill != '0);
  assign rec_out.data_length  = queue[rd_ptr].data_length;
  assign rec_out.zero_length  = queue[rd_ptr].zero_length;
  assign rec_out.final_record = queue[rd_ptr].final_record;

  // checks
  `ZRS_ASSERT_ALWAYS(a_fill_bound, fill <= FILL_MAX, "result queue overfilled")
  `ZRS_ASSERT_NEXT(a_fill_track, !rst, fill == $past(fill) + zrs_pkg::QUEUE_CW'($past(push_n)) - zrs_pkg::QUEUE_CW'($past(out_xfer)), "queue fill lost track of transfers")
  `ZRS_ASSERT_NEXT(a_end_clears, in_xfer && end_rec, kept_count == '0 && zero_run_count == '0, "counters not cleared at end of stream")
  `ZRS_ASSERT_NEXT(a_data_keeps, in_xfer && byte_nz && !end_rec, kept_count != '0 && zero_run_count == '0, "nonzero byte not counted as kept")

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// zero run segmenter testbench
// Drives byte streams into the segmenter under several zero thresholds and
// checks every record against a cycle-free model of the run counters.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
  localparam int PHASE_ITEMS = 160;

  typedef enum logic {ROW_BYTE, ROW_THRESHOLD} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [7:0] value;
    logic eos;
    bit typed;
    zrs_pkg::record_t typed_rec;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [zrs_pkg::THR_WIDTH-1:0] cfg_data;

  zrs_in_if byte_if ();
  zrs_out_if rec_if ();

  zero_run_segmenter_top dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .byte_in (byte_if),
    .rec_out (rec_if)
  );

  // shadow of the block state
  logic [zrs_pkg::THR_WIDTH-1:0] thr_shadow;
  logic [COUNT_W-1:0] kept_bytes;
  logic [COUNT_W-1:0] zero_run;

  zrs_pkg::record_t pending_records[$];
  stim_row_t stim_rows[$];
  int mismatches = 0;
  int sent_items = 0;
  bit idle_on = 1'b1;
  bit pause_on = 1'b0;

  always #6 clk = ~clk;

  // saturating counter add
  function automatic logic [COUNT_W-1:0] sat_sum(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[COUNT_W] ? COUNT_SAT : total[COUNT_W-1:0];
  endfunction

  // open record as reported, counts clipped to the output width
  function automatic zrs_pkg::record_t open_record(input logic is_final);
    zrs_pkg::record_t rec;
    logic [63:0] kept_wide;
    logic [63:0] zero_wide;
    kept_wide = 64'(kept_bytes);
    zero_wide = 64'(zero_run);
    rec.data_length = (kept_wide > 64'(zrs_pkg::OUT_MAX)) ? zrs_pkg::OUT_MAX
                                                          : kept_wide[zrs_pkg::OUT_WIDTH-1:0];
    rec.zero_length = (zero_wide > 64'(zrs_pkg::OUT_MAX)) ? zrs_pkg::OUT_MAX
                                                          : zero_wide[zrs_pkg::OUT_WIDTH-1:0];
    rec.final_record = is_final;
    return rec;
  endfunction

  // advance the run counters by one byte, return the records it closes
  function automatic int segment_step(input logic [7:0] b, input logic eos,
                                      output zrs_pkg::record_t recs[2]);
    int n;
    n = 0;
    recs[0] = '0;
    recs[1] = '0;
    if (b != 8'h00) begin
      if (zero_run != '0) begin
        if (zero_run <= COUNT_W'(thr_shadow)) begin
          kept_bytes = sat_sum(kept_bytes, zero_run);
        end else begin
          recs[n] = open_record(1'b0);
          n++;
          kept_bytes = '0;
        end
        zero_run = '0;
      end
      kept_bytes = sat_sum(kept_bytes, COUNT_W'(1));
    end else begin
      zero_run = sat_sum(zero_run, COUNT_W'(1));
    end
    if (eos) begin
      recs[n] = open_record(1'b1);
      n++;
      kept_bytes = '0;
      zero_run = '0;
    end
    return n;
  endfunction

  // one byte transfer, with random gaps and the occasional full drain
  task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed = 1'b0,
                           input zrs_pkg::record_t typed_rec = '0);
    zrs_pkg::record_t recs[2];
    int n;
    if (pause_on && $urandom_range(0, 63) == 0) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
      while (pending_records.size() != 0) @(posedge clk);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.end_of_stream <= eos;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    sent_items++;
    n = segment_step(b, eos, recs);
    if (typed) begin
      pending_records.push_back(typed_rec);
    end else begin
      for (int i = 0; i < n; i++) pending_records.push_back(recs[i]);
    end
  endtask

  // wait until every record is out, then let the pipeline settle
  task automatic drain;
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [zrs_pkg::THR_WIDTH-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_shadow = value;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [7:0] value, input logic eos,
                         input bit typed = 1'b0, input zrs_pkg::record_t typed_rec = '0);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.eos = eos;
    row.typed = typed;
    row.typed_rec = typed_rec;
    stim_rows.push_back(row);
  endtask

  // one random stream: zero runs placed around the threshold, or plain noise
  task automatic random_stream;
    int nseg;
    int zlen;
    int nz;
    int len;
    int thr;
    logic [7:0] b;
    thr = int'(thr_shadow);
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        b = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
        send_byte(b, i == len - 1);
      end
    end else begin
      nseg = $urandom_range(1, 5);
      for (int s = 0; s < nseg; s++) begin
        case ($urandom_range(0, 4))
          0: zlen = 0;
          1: zlen = thr;
          2: zlen = thr + 1;
          3: zlen = (thr >= 1) ? thr - 1 : 1;
          default: zlen = $urandom_range(1, 6);
        endcase
        if (zlen > 40 && $urandom_range(0, 7) != 0) zlen = $urandom_range(1, 6);
        repeat (zlen) send_byte(8'h00, 1'b0);
        nz = $urandom_range(0, 4);
        repeat (nz) send_byte(8'($urandom_range(1, 255)), 1'b0);
      end
      b = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
      send_byte(b, 1'b1);
    end
  endtask

  // record sink with random stalls, and the record check
  initial rec_if.ready = 1'b0;
  int stall_left = 0;
  always @(posedge clk) begin
    zrs_pkg::record_t want;
    if (rec_if.valid && rec_if.ready) begin
      if (pending_records.size() == 0) begin
        $error("unexpected record data_length=%0d zero_length=%0d final_record=%0b",
               rec_if.data_length, rec_if.zero_length, rec_if.final_record);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        if (rec_if.data_length !== want.data_length) begin
          $error("data_length expected %0d actual %0d", want.data_length, rec_if.data_length);
          mismatches++;
        end
        if (rec_if.zero_length !== want.zero_length) begin
          $error("zero_length expected %0d actual %0d", want.zero_length, rec_if.zero_length);
          mismatches++;
        end
        if (rec_if.final_record !== want.final_record) begin
          $error("final_record expected %0b actual %0b", want.final_record,
                 rec_if.final_record);
          mismatches++;
        end
      end
    end
    if (rst) begin
      rec_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rec_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      rec_if.ready <= 1'b0;
    end else begin
      rec_if.ready <= 1'b1;
    end
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  // stimulus
  initial begin
    logic [zrs_pkg::THR_WIDTH-1:0] phase_thr[7];
    int phase_end;
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= 8'h00;
    byte_if.end_of_stream <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    thr_shadow = zrs_pkg::THRESHOLD_RESET;
    kept_bytes = '0;
    zero_run = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset, threshold 8: lone bytes
    add_row(ROW_BYTE, 8'h00, 1'b1, 1'b1, '{32'd0, 32'd1, 1'b1});
    add_row(ROW_BYTE, 8'hFF, 1'b1, 1'b1, '{32'd1, 32'd0, 1'b1});
    // threshold 1: run equal to threshold folds, longer run closes,
    // short run at the end is reported as zeroes
    add_row(ROW_THRESHOLD, 8'd1, 1'b0);
    add_row(ROW_BYTE, 8'h80, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'h7F, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'h55, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b1);
    // long run closed by the last byte: two records
    add_row(ROW_BYTE, 8'h33, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'h44, 1'b1);
    // threshold 0: any zero closes the record
    add_row(ROW_THRESHOLD, 8'd0, 1'b0);
    add_row(ROW_BYTE, 8'h0A, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'h2B, 1'b1);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b1, 1'b1, '{32'd0, 32'd2, 1'b1});
    // threshold 255: short run folded
    add_row(ROW_THRESHOLD, 8'd255, 1'b0);
    add_row(ROW_BYTE, 8'h01, 1'b0);
    add_row(ROW_BYTE, 8'h00, 1'b0);
    add_row(ROW_BYTE, 8'hD2, 1'b1);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_THRESHOLD) begin
        write_threshold(stim_rows[i].value);
      end else begin
        send_byte(stim_rows[i].value, stim_rows[i].eos, stim_rows[i].typed,
                  stim_rows[i].typed_rec);
      end
    end

    // random streams under several thresholds, the last phase without idling
    phase_thr[0] = 8'd8;
    phase_thr[1] = 8'd0;
    phase_thr[2] = 8'd255;
    phase_thr[3] = 8'd1;
    phase_thr[4] = 8'($urandom_range(2, 20));
    phase_thr[5] = 8'($urandom_range(0, 255));
    phase_thr[6] = 8'd8;
    pause_on = 1'b1;
    for (int p = 0; p < 7; p++) begin
      write_threshold(phase_thr[p]);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        idle_on = (p == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
        if (p == 6) pause_on = 1'b0;
        random_stream();
      end
    end

    // wait for the tail, then look for stray records
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* zero_run_segmenter_top.f */
+incdir+design
design/zrs_pkg.sv
design/zrs_channels.sv
design/zero_run_segmenter_top.sv
dv/tb.sv
